>>> hw/rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and opcodes for the Q24.8 fixed-point ALU
// Holds the opcode enum and the word that travels along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_EQ  = 4'd4, OP_NE  = 4'd5, OP_GT  = 4'd6, OP_LT  = 4'd7,
    OP_GE  = 4'd8, OP_LE  = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
    OP_FROM_INT = 4'd12, OP_TO_INT = 4'd13
  } op_t;

  localparam int W = 32;
  // Divider numerator: |a| << frac, doubled, plus |b|; 32 + 16 + 2 bits.
  localparam int NW = 50;
  localparam int DW = 34;

  // Word handed from cell to cell: one long-division step per cell.
  typedef struct packed {
    logic          vld;
    logic [3:0]    cmd;
    logic [NW-1:0] num;   // numerator bits still to be shifted in
    logic [DW-1:0] rem;   // partial remainder
    logic [DW-1:0] den;   // 2*|b|
    logic [NW-1:0] quo;   // quotient bits
    logic          neg;
    logic          dz;
    logic [2*W-1:0] prd;  // product magnitude, rounded at the tail
    logic [W-1:0]  res;   // result for non-divide ops
    logic          cmp;
    logic          ov;
  } cell_t;

endpackage
`default_nettype wire

>>> hw/rtl/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: signed Q24.8 arithmetic unit
//
//   channel | ports                                  | direction
//   in      | in_valid in_stall in_cmd in_operand_a/b | word in
//   out     | out_valid out_stall out_result_value .. | word out
//
// One word per cycle while out does not stall; each word passes through the chain of
// division cells (one quotient bit per cell), and all opcodes share the chain.
// Multiply carries the product magnitude; round and saturate it at the tail.
// Reset clears every valid bit in the chain.
// A stall on out freezes the whole chain and stalls in when the last
// cell is full.
// ----------------------------------------------------------------------------
`default_nettype none
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         in_cmd,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_value,
  output logic                    out_compare_true,
  output logic                    out_overflow,
  output logic                    out_divide_by_zero
);
  localparam int N = fpa_pkg::NW;
  fpa_pkg::cell_t chain [0:N];
  fpa_pkg::cell_t tl;
  logic adv;
  logic [fpa_pkg::NW-1:0] q;
  logic [31:0] r;
  logic ov;
  logic [63:0] pr;
  logic [31:0] mr;
  logic mov;

  assign adv      = !(chain[N].vld && out_stall);
  assign in_stall = !adv;

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .vld(in_valid), .cmd(in_cmd), .a(in_operand_a), .b(in_operand_b),
    .w(chain[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    fpa_cell u_cell (.clk(clk), .rst_n(rst_n), .adv(adv),
                     .d_in(chain[i]), .d_out(chain[i+1]));
  end

  always_comb begin
    tl = chain[N];
    q  = tl.quo;
    ov = (q > fpa_pkg::NW'(32'h7fffffff)) &&
         !(tl.neg && q == fpa_pkg::NW'(33'h080000000));
    if (ov) r = tl.neg ? 32'h80000000 : 32'h7fffffff;
    else    r = tl.neg ? 32'(-q) : q[31:0];
    pr  = (tl.prd + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    mov = (pr > 64'h7fffffff) && !(tl.neg && pr == 64'h80000000);
    if (mov) mr = tl.neg ? 32'h80000000 : 32'h7fffffff;
    else     mr = tl.neg ? 32'(-pr) : pr[31:0];
  end

  assign out_valid          = tl.vld;
  assign out_compare_true   = tl.cmp;
  assign out_divide_by_zero = (tl.cmd == fpa_pkg::OP_DIV) && tl.dz;
  assign out_overflow       = (tl.cmd == fpa_pkg::OP_DIV) ? (!tl.dz && ov) :
                              (tl.cmd == fpa_pkg::OP_MUL) ? mov : tl.ov;
  assign out_result_value   = (tl.cmd == fpa_pkg::OP_DIV) ? (tl.dz ? '0 : r) :
                              (tl.cmd == fpa_pkg::OP_MUL) ? mr : tl.res;

  property p_stall;
    @(posedge clk) disable iff (!rst_n) (out_valid && out_stall) |=> out_valid;
  endproperty
  a_stall: assert property (p_stall) else $error("result lost");
  a_install: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)) else $error("spurious stall");
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_result_value == '0 && !out_overflow))
    else $error("divide by zero result");
endmodule
`default_nettype wire

>>> hw/rtl/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell: one restoring long-division step
// Shifts one numerator bit into the remainder and passes the word on.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire fpa_pkg::cell_t d_in,
  output fpa_pkg::cell_t      d_out
);
  fpa_pkg::cell_t w_r, w_nxt;
  logic [fpa_pkg::DW:0] tr;

  always_comb begin
    w_nxt = d_in;
    tr    = {d_in.rem, d_in.num[fpa_pkg::NW-1]};
    w_nxt.num = {d_in.num[fpa_pkg::NW-2:0], 1'b0};
    if (tr >= {1'b0, d_in.den}) begin
      w_nxt.rem = fpa_pkg::DW'(tr - {1'b0, d_in.den});
      w_nxt.quo = {d_in.quo[fpa_pkg::NW-2:0], 1'b1};
    end else begin
      w_nxt.rem = tr[fpa_pkg::DW-1:0];
      w_nxt.quo = {d_in.quo[fpa_pkg::NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r.vld <= 1'b0;
    end else if (adv) begin
      w_r <= w_nxt;
    end
  end

  assign d_out = w_r;
endmodule
`default_nettype wire

>>> hw/rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: operand decode and combinational operations
// Computes add, sub, compares, inc, dec, conversions and the product,
// and sets up the division word.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic                       vld,
  input  wire logic [3:0]                 cmd,
  input  wire logic signed [31:0]         a,
  input  wire logic signed [31:0]         b,
  output fpa_pkg::cell_t                  w
);
  localparam logic signed [63:0] MAXV = 64'sd2147483647;
  localparam logic signed [63:0] MINV = -64'sd2147483648;
  logic [31:0] am, bm;
  logic [47:0] nm;
  logic [31:0] ti;

  function automatic logic [32:0] sat(input logic signed [63:0] v);
    if (v > MAXV) sat = {1'b1, 32'h7fffffff};
    else if (v < MINV) sat = {1'b1, 32'h80000000};
    else sat = {1'b0, v[31:0]};
  endfunction

  always_comb begin
    w      = '0;
    w.vld  = vld;
    w.cmd  = cmd;
    am     = a[31] ? 32'(-a) : a;
    bm     = b[31] ? 32'(-b) : b;
    nm     = 48'(am) << FRAC_BITS;
    ti     = 32'(a >>> FRAC_BITS);
    w.prd  = am * bm;
    w.den  = {1'b0, bm, 1'b0};
    w.num  = fpa_pkg::NW'({nm, 1'b0} + {17'd0, bm});
    w.neg  = a[31] ^ b[31];
    w.dz   = (b == 32'sd0);
    unique case (cmd)
      fpa_pkg::OP_ADD:      {w.ov, w.res} = sat(64'(a) + 64'(b));
      fpa_pkg::OP_SUB:      {w.ov, w.res} = sat(64'(a) - 64'(b));
      fpa_pkg::OP_EQ:       w.cmp = (a == b);
      fpa_pkg::OP_NE:       w.cmp = (a != b);
      fpa_pkg::OP_GT:       w.cmp = (a > b);
      fpa_pkg::OP_LT:       w.cmp = (a < b);
      fpa_pkg::OP_GE:       w.cmp = (a >= b);
      fpa_pkg::OP_LE:       w.cmp = (a <= b);
      fpa_pkg::OP_INC:      {w.ov, w.res} = sat(64'(a) + 64'sd1);
      fpa_pkg::OP_DEC:      {w.ov, w.res} = sat(64'(a) - 64'sd1);
      fpa_pkg::OP_FROM_INT: {w.ov, w.res} = sat(64'(a) <<< FRAC_BITS);
      fpa_pkg::OP_TO_INT:   w.res = ti;
      default:              w.res = '0;
    endcase
  end
endmodule
`default_nettype wire
